// ----- hw/rtl/touch_velocity_ewma_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Touch velocity filter assertion macros
// Property checks for simulation; they expand to nothing when synthesising.
// ----------------------------------------------------------------------------
`ifndef TOUCH_VELOCITY_EWMA_FILTER_DEFINES_SVH
`define TOUCH_VELOCITY_EWMA_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TVEF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TVEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TVEF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define TVEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/tvef_pkg.sv -----
// ----------------------------------------------------------------------------
// tvef_pkg
// Types and constants shared by the touch velocity filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tvef_pkg;

    // Field widths.
    localparam int POS_W   = 20;
    localparam int DT_W    = 16;
    localparam int TC_W    = 16;
    localparam int VEL_W   = 24;
    localparam int SPEED_W = 47;

    // Two axes, each with its own lane in the datapath.
    localparam int AXES   = 2;
    localparam int AXIS_V = 0;
    localparam int AXIS_H = 1;

    // Iterative divider: 34-bit dividend, 16-bit divisor, two quotient bits a step.
    localparam int DIV_W         = 34;
    localparam int DIV_D_W       = 16;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = 5;

    // Internal arithmetic widths.
    localparam int DELTA_W    = POS_W + 1;
    localparam int RAW_SHIFT  = 12;
    localparam int RAW_W      = 34;
    localparam int DIFF_W     = 35;
    localparam int ALPHA_W    = 16;
    localparam int SPLIT      = 18;
    localparam int PROD_W     = 34;
    localparam int ACC_W      = 52;
    localparam int FRAC_W     = 16;
    localparam int NV_W       = 37;
    localparam int SQ_W       = 2 * VEL_W;

    localparam logic [ALPHA_W-1:0] ALPHA_CAP  = 16'd52429;
    localparam logic [ACC_W-1:0]   ROUND_HALF = 52'd32768;
    localparam logic [TC_W-1:0]    TC_RESET   = 16'd50;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -24'sh800000;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_TIME_CONSTANT = 1'b0;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [VEL_W-1:0] vel_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vertical_position;
        logic signed [POS_W-1:0] horizontal_position;
        logic [DT_W-1:0]         elapsed_ms;
    } tvef_event_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vertical_velocity;
        logic signed [VEL_W-1:0] horizontal_velocity;
        logic [SPEED_W-1:0]      speed_squared;
        logic                    updated;
    } tvef_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_RAW,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_UPDATE,
        ST_SQUARE,
        ST_SUM
    } tvef_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mark_start;
        logic upd_load;
        logic upd_value;
        logic div_start;
        logic raw_en;
        logic diff_en;
        logic mul_lo_en;
        logic mul_hi_en;
        logic acc_en;
        logic vel_en;
        logic sq_en;
        logic out_load;
    } tvef_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic started;
        logic dt_zero;
        logic div_busy;
        logic out_busy;
    } tvef_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tvef_div.sv -----
// ----------------------------------------------------------------------------
// tvef_div
// Unsigned restoring divider, two quotient bits per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module tvef_div
    import tvef_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    busy,
    output logic [DIV_W-1:0]        quotient
);

    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_CNT_W-1:0] count_next;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;

    // The quotient register starts as the dividend and shifts the quotient in
    // at the bottom as the dividend bits leave at the top.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        diff     = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            diff     = trial - {1'b0, divisor};
            if (trial >= {1'b0, divisor})
            begin
                rem_next    = diff[DIV_D_W-1:0];
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_D_W-1:0];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (start)
        begin
            count_next = DIV_CNT_W'(DIV_STEPS);
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tvef_datapath.sv -----
// ----------------------------------------------------------------------------
// tvef_datapath
// Per-axis velocity lanes, smoothing factor, squared speed and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tvef_datapath
    import tvef_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tvef_cmd_t       cmd,
    output tvef_sts_t            sts,
    input  wire tvef_event_t     event_word,
    input  wire logic [TC_W-1:0] time_constant_ms,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output tvef_result_t         result_word
);

    // Captured event.
    pos_t                 pos_reg [AXES];
    logic [DT_W-1:0]      dt_reg;

    // Filter state.
    logic                 started_reg;
    pos_t                 last_reg [AXES];
    vel_t                 vel_reg [AXES];
    vel_t                 vel_next [AXES];
    logic                 upd_reg;

    // Lane working registers.
    logic                      sign_reg [AXES];
    logic [DELTA_W-1:0]        delta [AXES];
    logic [DELTA_W-1:0]        mag [AXES];
    logic [DIV_W-1:0]          lane_dividend [AXES];
    logic [DIV_W-1:0]          lane_quo [AXES];
    logic                      lane_busy [AXES];
    logic signed [RAW_W-1:0]   raw_reg [AXES];
    logic signed [RAW_W-1:0]   raw_next [AXES];
    logic signed [DIFF_W-1:0]  diff_reg [AXES];
    logic signed [DIFF_W-1:0]  diff_next [AXES];
    logic [PROD_W-1:0]         plo_reg [AXES];
    logic [PROD_W-1:0]         plo_next [AXES];
    logic signed [PROD_W-1:0]  phi_reg [AXES];
    logic signed [PROD_W-1:0]  phi_next [AXES];
    logic signed [ACC_W-1:0]   acc_reg [AXES];
    logic signed [ACC_W-1:0]   acc_next [AXES];
    logic signed [NV_W-1:0]    nv [AXES];
    logic signed [SQ_W-1:0]    sq_prod [AXES];
    logic [SPEED_W-1:0]        sq_reg [AXES];

    // Smoothing factor.
    logic [DIV_W-1:0]   alpha_dividend;
    logic [DIV_W-1:0]   alpha_quo;
    logic               alpha_busy;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] alpha_next;

    // Output stage.
    logic [SPEED_W:0]   speed_sum;
    logic [SPEED_W-1:0] speed_sat;
    tvef_result_t       result_reg;
    tvef_result_t       result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    // Frame deltas and divider operands; the quotient is the magnitude of
    // delta * 4096 / dt and the sign is put back afterwards.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            delta[a] = {pos_reg[a][POS_W-1], pos_reg[a]}
                     - {last_reg[a][POS_W-1], last_reg[a]};
            mag[a]   = delta[a][DELTA_W-1] ? (~delta[a] + 1'b1) : delta[a];
            lane_dividend[a] = {1'b0, mag[a], {RAW_SHIFT{1'b0}}};
        end
        alpha_dividend = {2'b00, dt_reg, {FRAC_W{1'b0}}};
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane_div
        tvef_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (cmd.div_start),
            .dividend (lane_dividend[g]),
            .divisor  (dt_reg),
            .busy     (lane_busy[g]),
            .quotient (lane_quo[g])
        );
    end

    tvef_div u_alpha_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (alpha_dividend),
        .divisor  (time_constant_ms),
        .busy     (alpha_busy),
        .quotient (alpha_quo)
    );

    // Arithmetic for each step of the filter update.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            raw_next[a]  = sign_reg[a] ? -$signed(lane_quo[a]) : $signed(lane_quo[a]);
            diff_next[a] = DIFF_W'(raw_reg[a]) - DIFF_W'(vel_reg[a]);
            plo_next[a]  = PROD_W'(alpha_reg) * PROD_W'(diff_reg[a][SPLIT-1:0]);
            phi_next[a]  = PROD_W'($signed({1'b0, alpha_reg}))
                         * PROD_W'($signed(diff_reg[a][DIFF_W-1:SPLIT]));
            acc_next[a]  = (ACC_W'(phi_reg[a]) <<< SPLIT)
                         + $signed(ACC_W'(plo_reg[a]))
                         + $signed(ROUND_HALF);
            // Arithmetic shift of the rounded product gives round half up.
            nv[a] = NV_W'(vel_reg[a]) + NV_W'($signed(acc_reg[a][ACC_W-1:FRAC_W]));
            if (nv[a] > NV_W'(VEL_MAX))
            begin
                vel_next[a] = VEL_MAX;
            end
            else if (nv[a] < NV_W'(VEL_MIN))
            begin
                vel_next[a] = VEL_MIN;
            end
            else
            begin
                vel_next[a] = nv[a][VEL_W-1:0];
            end
            sq_prod[a] = SQ_W'(vel_reg[a]) * SQ_W'(vel_reg[a]);
        end

        if ((time_constant_ms == '0) || (alpha_quo >= DIV_W'(ALPHA_CAP)))
        begin
            alpha_next = ALPHA_CAP;
        end
        else
        begin
            alpha_next = alpha_quo[ALPHA_W-1:0];
        end
    end

    // Only both velocities at full negative scale overflow the sum.
    always_comb
    begin
        speed_sum = {1'b0, sq_reg[AXIS_V]} + {1'b0, sq_reg[AXIS_H]};
        speed_sat = speed_sum[SPEED_W] ? {SPEED_W{1'b1}} : speed_sum[SPEED_W-1:0];

        result_next.vertical_velocity   = vel_reg[AXIS_V];
        result_next.horizontal_velocity = vel_reg[AXIS_H];
        result_next.speed_squared       = speed_sat;
        result_next.updated             = upd_reg;

        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                last_reg[a] <= '0;
                vel_reg[a]  <= '0;
            end
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cmd.mark_start)
            begin
                started_reg <= 1'b1;
            end
            for (int a = 0; a < AXES; a++)
            begin
                if (cmd.mark_start)
                begin
                    last_reg[a] <= '0;
                end
                else if (cmd.div_start)
                begin
                    last_reg[a] <= pos_reg[a];
                end
                if (cmd.vel_en)
                begin
                    vel_reg[a] <= vel_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pos_reg[AXIS_V] <= event_word.vertical_position;
            pos_reg[AXIS_H] <= event_word.horizontal_position;
            dt_reg          <= event_word.elapsed_ms;
        end
        if (cmd.upd_load)
        begin
            upd_reg <= cmd.upd_value;
        end
        if (cmd.raw_en)
        begin
            alpha_reg <= alpha_next;
        end
        for (int a = 0; a < AXES; a++)
        begin
            if (cmd.div_start)
            begin
                sign_reg[a] <= delta[a][DELTA_W-1];
            end
            if (cmd.raw_en)
            begin
                raw_reg[a] <= raw_next[a];
            end
            if (cmd.diff_en)
            begin
                diff_reg[a] <= diff_next[a];
            end
            if (cmd.mul_lo_en)
            begin
                plo_reg[a] <= plo_next[a];
            end
            if (cmd.mul_hi_en)
            begin
                phi_reg[a] <= phi_next[a];
            end
            if (cmd.acc_en)
            begin
                acc_reg[a] <= acc_next[a];
            end
            if (cmd.sq_en)
            begin
                sq_reg[a] <= sq_prod[a][SPEED_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign sts.started  = started_reg;
    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.div_busy = lane_busy[AXIS_V] | lane_busy[AXIS_H] | alpha_busy;
    assign sts.out_busy = result_valid_reg & result_stall;

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tvef_ctrl.sv -----
// ----------------------------------------------------------------------------
// tvef_ctrl
// Sequencer that steps the datapath through one event at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tvef_ctrl
    import tvef_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      event_valid,
    output logic           event_stall,
    input  wire tvef_sts_t sts,
    output tvef_cmd_t      cmd
);

    tvef_state_t state_reg;
    tvef_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (event_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.started || sts.dt_zero)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACCUM;
            ST_ACCUM:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd         = '0;
        event_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = event_valid;
            end
            ST_CHECK:
            begin
                cmd.upd_load = 1'b1;
                if (!sts.started)
                begin
                    cmd.mark_start = 1'b1;
                end
                else if (!sts.dt_zero)
                begin
                    cmd.upd_value = 1'b1;
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIVIDE: cmd = '0;
            ST_RAW:    cmd.raw_en    = 1'b1;
            ST_DIFF:   cmd.diff_en   = 1'b1;
            ST_MUL_LO: cmd.mul_lo_en = 1'b1;
            ST_MUL_HI: cmd.mul_hi_en = 1'b1;
            ST_ACCUM:  cmd.acc_en    = 1'b1;
            ST_UPDATE: cmd.vel_en    = 1'b1;
            ST_SQUARE: cmd.sq_en     = 1'b1;
            ST_SUM:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/touch_velocity_ewma_filter.sv -----
// ----------------------------------------------------------------------------
// touch_velocity_ewma_filter: smoothed touch velocity with squared speed
// A new event is accepted only once the previous one has been fully processed.
// Reset clears the filter state and sets the time constant to 50 ms.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_velocity_ewma_filter_defines.svh"

// Each event word carries the cumulative displacement on both axes, in
// sixteenths of a pixel, and the milliseconds since the previous event. The
// block keeps an exponential moving average of the velocity on each axis in
// signed Q8.16 pixels per millisecond and returns one result word per event.
//
// Processing of one event:
//   - The first event after reset marks the filter started and clears the
//     stored positions; the velocities are kept and the result is flagged as
//     not updated.
//   - An event with zero elapsed time leaves all state untouched and is also
//     flagged as not updated.
//   - Otherwise the frame deltas are formed, the positions stored, and three
//     dividers run side by side: one per axis for delta * 4096 / dt, and one
//     for dt * 65536 / time_constant, capped at 0.8 in Q0.16. A divider
//     yields two quotient bits a clock, and the division dominates the
//     processing time.
//   - Each velocity then moves towards its raw value by the smoothing factor.
//     The product is split into two narrow multiplications on successive
//     clocks, summed, rounded half up and saturated to 24 bits.
//   - The squares of both velocities are registered and summed, saturating at
//     the top of the 47-bit range, into the result register.
//
// The result register decouples the two sides: a new event is accepted while
// the previous result still waits, and the sequencer only holds in its final
// step when that register is still occupied.
//
// The time constant lies at byte address 0 of the register port. It is to be
// written only while no event is in flight.

module touch_velocity_ewma_filter
    import tvef_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               event_valid,
    output logic                    event_stall,
    input  wire tvef_event_t        event_word,

    output logic                    result_valid,
    input  wire logic               result_stall,
    output tvef_result_t            result_word,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    tvef_cmd_t        cmd;
    tvef_sts_t        sts;
    logic [TC_W-1:0]  tc_reg;
    logic [TC_W-1:0]  tc_next;
    logic             reg_hit;
    logic             event_accept;

    // Register port. Word index is taken from the address above the byte
    // offset; addresses beyond the single register read as zero and ignore
    // writes.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_TIME_CONSTANT);

    always_comb
    begin
        tc_next = tc_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            tc_next = pwdata[TC_W-1:0];
        end
        prdata = reg_hit ? PDATA_W'(tc_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= TC_RESET;
        end
        else
        begin
            tc_reg <= tc_next;
        end
    end

    // The sequencer decides the order of operations; the datapath holds all
    // arithmetic and the result register.
    tvef_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    tvef_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .event_word       (event_word),
        .time_constant_ms (tc_reg),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result_word      (result_word)
    );

    assign event_accept = event_valid & ~event_stall;

    // Once an event is taken, no further event is taken until it is done.
    `TVEF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, event_accept, event_stall, "event accepted while busy")
    // A waiting result is never overwritten.
    `TVEF_ASSERT_SAME(a_no_result_overwrite, clk, rst_n, cmd.out_load, !sts.out_busy, "result overwritten")
    // Starting the dividers always leaves them busy on the next clock.
    `TVEF_ASSERT_NEXT(a_divider_runs, clk, rst_n, cmd.div_start, sts.div_busy, "divider did not start")

endmodule

`default_nettype wire
